>>> hdl/pkht_pkg.sv
// Shared types and constants for the pair-key hash table.
package pkht_pkg;

  localparam int KEY_W   = 64;
  localparam int FIELD_W = 24;
  localparam int CFG_W   = 4;

  // Key mixer and capacity constants
  localparam logic [63:0]      MIX_MULT     = 64'hff51afd7ed558ccd;
  localparam int               MIX_SHIFT    = 33;
  localparam logic [CFG_W-1:0] MIN_CAP_LOG2 = 4'd4;
  localparam logic [CFG_W-1:0] CAP_LOG2_RST = 4'd10;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  // Steps of the shared 32x32 multiplier
  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_LL,
    MUL_LH,
    MUL_HL,
    MUL_END
  } mul_step_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL_LL,
    S_MUL_LH,
    S_MUL_HL,
    S_MUL_END,
    S_HOME,
    S_READ,
    S_CHECK
  } ctl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic      load_item;
    mul_step_e mul_step;
    logic      set_home;
    logic      rd_en;
    logic      advance;
    logic      clr_wr;
    logic      ins_wr;
    logic      out_load;
    logic      out_found;
    status_e   out_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic slot_valid;
    logic key_match;
    logic probe_last;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/pair_key_hash_table.sv
// Top level of the pair-key hash table: controller, datapath and checks.
//
// Input channel (in_valid_i / in_stall_o) takes one word: op_i (lookup or
// insert), pair_key_i, new_rank_i, new_result_i. Output channel
// (out_valid_o / out_stall_i) returns one word per input word: status_o,
// found_rank_o, found_result_o. A word moves at an edge with valid high and
// stall low. Config channel (cfg_valid_i / cfg_ready_o) writes capacity_log2;
// it is always ready and should be written only while the table is idle.
// Timing: after accepting a word the key is mixed in the steps MUL_LL,
// MUL_LH, MUL_HL and MUL_END on one 32x32 multiplier, then the home slot is
// formed, then slots are probed, each probe a memory read, then a compare.
// No new word is taken until the result is loaded into the output register,
// so one word is in flight at a time, and its probe loop runs through the
// slot memory's one read port.
// Reset: a clearing pass walks the slot memory, one slot per cycle, up to
// the all-ones index; in_stall_o stays high until it ends.
// Stall: a finished result sits in the output register; while out_stall_i
// holds it, the next word is still accepted and worked on, and only its final
// step waits for the register to drain.
module pair_key_hash_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pkht_pkg::CFG_W-1:0]   cfg_capacity_log2_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [pkht_pkg::KEY_W-1:0]   pair_key_i,
  input  logic [pkht_pkg::FIELD_W-1:0] new_rank_i,
  input  logic [pkht_pkg::FIELD_W-1:0] new_result_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [pkht_pkg::FIELD_W-1:0] found_rank_o,
  output logic [pkht_pkg::FIELD_W-1:0] found_result_o
);
  import pkht_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;

  pkht_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pkht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_capacity_log2_i),
    .op_i           (op_i),
    .pair_key_i     (pair_key_i),
    .new_rank_i     (new_rank_i),
    .new_result_i   (new_result_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_rank_o   (found_rank_o),
    .found_result_o (found_result_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  // An insert never overwrites a live slot
  a_ins_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_wr |-> !sts.slot_valid)
    else $error("insert wrote over a valid slot");

  // A result is loaded only when the output register can take it
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overrun");

  // One word at a time: the input side is busy after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input accepted while a word is in flight");

  // Duplicate status only comes from an insert
  a_dup_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && cmd.out_status == ST_DUP) |-> sts.is_insert)
    else $error("duplicate status on a lookup");

endmodule

>>> hdl/pkht_ctl.sv
// Sequencing state machine for hashing, probing and clearing the table.
module pkht_ctl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pkht_pkg::dp_sts_t sts_i,
  output pkht_pkg::dp_cmd_t cmd_o
);
  import pkht_pkg::*;

  ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.mul_step     = MUL_IDLE;
    cmd_o.out_status   = ST_OK;
    in_stall_o         = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_MUL_LL;
        end
      end
      S_MUL_LL: begin
        cmd_o.mul_step = MUL_LL;
        state_d        = S_MUL_LH;
      end
      S_MUL_LH: begin
        cmd_o.mul_step = MUL_LH;
        state_d        = S_MUL_HL;
      end
      S_MUL_HL: begin
        cmd_o.mul_step = MUL_HL;
        state_d        = S_MUL_END;
      end
      S_MUL_END: begin
        cmd_o.mul_step = MUL_END;
        state_d        = S_HOME;
      end
      S_HOME: begin
        cmd_o.set_home = 1'b1;
        state_d        = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        // finishing waits until the output register can take the word
        if (!sts_i.slot_valid) begin
          if (sts_i.out_free) begin
            cmd_o.ins_wr     = sts_i.is_insert;
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = sts_i.is_insert ? ST_OK : ST_MISS;
            state_d          = S_IDLE;
          end
        end else if (sts_i.key_match) begin
          if (sts_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_found  = !sts_i.is_insert;
            cmd_o.out_status = sts_i.is_insert ? ST_DUP : ST_OK;
            state_d          = S_IDLE;
          end
        end else if (sts_i.probe_last) begin
          if (sts_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_FULL;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/pkht_dp.sv
// Datapath: item registers, key mixer, slot memory, probe index and output register.
module pkht_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pkht_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            op_i,
  input  logic [pkht_pkg::KEY_W-1:0]      pair_key_i,
  input  logic [pkht_pkg::FIELD_W-1:0]    new_rank_i,
  input  logic [pkht_pkg::FIELD_W-1:0]    new_result_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [pkht_pkg::FIELD_W-1:0]    found_rank_o,
  output logic [pkht_pkg::FIELD_W-1:0]    found_result_o,
  input  pkht_pkg::dp_cmd_t               cmd_i,
  output pkht_pkg::dp_sts_t               sts_o
);
  import pkht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [FIELD_W-1:0] rank;
    logic [FIELD_W-1:0] result;
  } slot_t;

  logic [CFG_W-1:0]   cap_log2_q;
  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [FIELD_W-1:0] rank_q;
  logic [FIELD_W-1:0] result_q;
  logic [63:0]        prod_q;
  logic [63:0]        acc_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   visited_q;
  logic [IDX_W-1:0]   clr_cnt_q;
  slot_t              rd_q;
  logic               out_valid_q;
  status_e            status_q;
  logic [FIELD_W-1:0] found_rank_q;
  logic [FIELD_W-1:0] found_result_q;

  logic [CFG_W-1:0]   lg_eff;
  logic [IDX_W-1:0]   mask;
  logic [63:0]        pre_mix;
  logic [63:0]        mix;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        prod_d;
  logic               out_free;

  slot_t mem [TABLE_DEPTH];

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q <= CAP_LOG2_RST;
    end else if (cfg_we_i) begin
      cap_log2_q <= cfg_data_i;
    end
  end

  // Index mask for the capacity in use, floored at the minimum, capped at depth
  always_comb begin
    lg_eff = (cap_log2_q < MIN_CAP_LOG2) ? MIN_CAP_LOG2 : cap_log2_q;
    for (int i = 0; i < IDX_W; i++) begin
      mask[i] = (int'(lg_eff) > i);
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= op_i;
      key_q    <= pair_key_i;
      rank_q   <= new_rank_i;
      result_q <= new_result_i;
    end
  end

  // Mixer: 64-bit product low half from three 32x32 partial products
  assign pre_mix = key_q ^ (key_q >> MIX_SHIFT);

  always_comb begin
    case (cmd_i.mul_step)
      MUL_LH: begin
        mul_a = pre_mix[31:0];
        mul_b = MIX_MULT[63:32];
      end
      MUL_HL: begin
        mul_a = pre_mix[63:32];
        mul_b = MIX_MULT[31:0];
      end
      default: begin
        mul_a = pre_mix[31:0];
        mul_b = MIX_MULT[31:0];
      end
    endcase
  end

  assign prod_d = {32'b0, mul_a} * {32'b0, mul_b};

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul_step)
      MUL_LL: begin
        prod_q <= prod_d;
      end
      MUL_LH: begin
        prod_q <= prod_d;
        acc_q  <= prod_q;
      end
      MUL_HL: begin
        prod_q <= prod_d;
        acc_q  <= acc_q + {prod_q[31:0], 32'b0};
      end
      MUL_END: begin
        acc_q <= acc_q + {prod_q[31:0], 32'b0};
      end
      default: begin
      end
    endcase
  end

  assign mix = acc_q ^ (acc_q >> MIX_SHIFT);

  // Probe index and visit count
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_home) begin
      idx_q     <= mix[IDX_W-1:0] & mask;
      visited_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q     <= (idx_q + 1'b1) & mask;
      visited_q <= visited_q + 1'b1;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.ins_wr) begin
      mem[idx_q] <= '{valid: 1'b1, key: key_q, rank: rank_q, result: result_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q       <= cmd_i.out_status;
      found_rank_q   <= cmd_i.out_found ? rd_q.rank : '0;
      found_result_q <= cmd_i.out_found ? rd_q.result : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_rank_o   = found_rank_q;
  assign found_result_o = found_result_q;

  // Status to controller
  assign sts_o.is_insert  = (op_q == OP_INSERT);
  assign sts_o.slot_valid = rd_q.valid;
  assign sts_o.key_match  = (rd_q.key == key_q);
  assign sts_o.probe_last = (visited_q == mask);
  assign sts_o.clr_last   = (clr_cnt_q == {IDX_W{1'b1}});
  assign sts_o.out_free   = out_free;

endmodule
